@@ design/bfla_pkg.sv @@
// Shared types and constants for the free-list block allocator.
// No dependencies; imported by every module of the block except bfla_ram.
`timescale 1ns / 1ps

package bfla_pkg;

  localparam int BLOCK_COUNT_DEF = 1024;
  localparam int PTR_W           = 10;
  localparam int USED_W          = 11;
  localparam int ACT_W           = 3;
  localparam int SIZE_W          = 7;
  localparam int STAT_W          = 2;
  localparam int KB_SHIFT        = 4;
  localparam int USED_MAX        = 2047;

  localparam logic [ACT_W-1:0] ACT_FORMAT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FREE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CHAIN  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LINK   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PTR_W-1:0]  block_index;
    logic [PTR_W-1:0]  link_target;
    logic [SIZE_W-1:0] size_kb;
  } req_t;

  typedef struct packed {
    logic [PTR_W-1:0]  block_out;
    logic [STAT_W-1:0] status;
    logic [USED_W-1:0] used_count;
    logic [PTR_W-1:0]  free_head;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FMT,
    S_WALK,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic fmt_step;
    logic walk_step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_fmt;     // format with at least two blocks
    logic in_walk;    // chain release on a valid block
    logic fmt_last;
    logic walk_stop;
  } stat_t;

endpackage

@@ design/bfla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bfla_ctrl.sv @@
// Sequencing state machine for the allocator.
// Depends on bfla_pkg; drives the datapath through cmd_t, watches stat_t.
`timescale 1ns / 1ps

module bfla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bfla_pkg::stat_t stat,
  output bfla_pkg::cmd_t  cmd,
  output logic            busy
);
  import bfla_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.in_fmt) begin
            state_next = S_FMT;
          end else if (stat.in_walk) begin
            state_next = S_WALK;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FMT: begin
        cmd.fmt_step = 1'b1;
        if (stat.fmt_last) begin
          state_next = S_FIN;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_stop) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bfla_datapath.sv @@
// Datapath: next-pointer table, free-list head, used count, walk and format counters.
// Depends on bfla_pkg and bfla_ram; controlled by bfla_ctrl.
`timescale 1ns / 1ps

module bfla_datapath #(
  parameter int BLOCK_COUNT = bfla_pkg::BLOCK_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bfla_pkg::req_t  req,
  input  bfla_pkg::cmd_t  cmd,
  output bfla_pkg::stat_t stat,
  output logic            done,
  output bfla_pkg::rsp_t  rsp
);
  import bfla_pkg::*;

  localparam int AW    = $clog2(BLOCK_COUNT);
  localparam int CNT_W = $clog2(BLOCK_COUNT + 2);
  localparam int SUB_W = (CNT_W > USED_W) ? CNT_W : USED_W;
  // caps both the format length and the used count
  localparam int LIMIT = (BLOCK_COUNT < USED_MAX) ? BLOCK_COUNT : USED_MAX;

  req_t              req_q;
  logic              valid_q;
  logic              target_ok_q;
  logic [PTR_W-1:0]  head;
  logic [USED_W-1:0] used;
  logic [PTR_W-1:0]  last;
  logic [CNT_W-1:0]  count;
  logic              too_long;
  logic [USED_W-1:0] fmt_idx;
  logic [USED_W-1:0] fmt_total;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [PTR_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [PTR_W-1:0]  ram_rdata;

  logic              in_valid;
  logic              in_target_ok;
  logic [USED_W-1:0] in_sz16;
  logic [USED_W-1:0] in_total;
  logic              count_full;

  logic [PTR_W-1:0]  head_new;
  logic [USED_W-1:0] used_new;
  logic [PTR_W-1:0]  bout;
  logic [STAT_W-1:0] st;
  logic              fin_we;
  logic [AW-1:0]     fin_addr;
  logic [PTR_W-1:0]  fin_data;
  logic [SUB_W-1:0]  used_ext;
  logic [SUB_W-1:0]  cnt_ext;

  bfla_ram #(
    .WIDTH(PTR_W),
    .DEPTH(BLOCK_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // decode of the live request, used on the accept cycle
  always_comb begin
    in_valid     = (req.block_index != '0) && (32'(req.block_index) < BLOCK_COUNT);
    in_target_ok = 32'(req.link_target) < BLOCK_COUNT;
    in_sz16      = USED_W'(req.size_kb) << KB_SHIFT;
    in_total     = (32'(in_sz16) > LIMIT) ? USED_W'(LIMIT) : in_sz16;
  end

  assign count_full = (count == CNT_W'(BLOCK_COUNT));

  always_comb begin
    stat.in_fmt    = (req.action == ACT_FORMAT) && (in_total >= USED_W'(2));
    stat.in_walk   = (req.action == ACT_CHAIN) && in_valid;
    stat.fmt_last  = (fmt_idx == fmt_total - USED_W'(1));
    stat.walk_stop = (ram_rdata == '0) || count_full;
  end

  // read port: from the request on accept, else follow the chain
  always_comb begin
    if (cmd.accept) begin
      ram_raddr = (req.action == ACT_ALLOC) ? AW'(head) : AW'(req.block_index);
    end else begin
      ram_raddr = AW'(ram_rdata);
    end
  end

  // effect of the finishing cycle
  always_comb begin
    head_new = head;
    used_new = used;
    bout     = '0;
    st       = ST_OK;
    fin_we   = 1'b0;
    fin_addr = AW'(req_q.block_index);
    fin_data = head;
    used_ext = SUB_W'(used);
    cnt_ext  = SUB_W'(count);
    case (req_q.action)
      ACT_FORMAT: begin
        head_new = (fmt_total < USED_W'(2)) ? '0 : PTR_W'(1);
        used_new = USED_W'(1);
      end
      ACT_ALLOC: begin
        if (head == '0) begin
          st = ST_FULL;
        end else begin
          bout     = head;
          head_new = ram_rdata;
          if (32'(used) < LIMIT) begin
            used_new = used + USED_W'(1);
          end
        end
      end
      ACT_FREE: begin
        if (!valid_q) begin
          st = ST_IGNORED;
        end else begin
          fin_we   = 1'b1;
          head_new = req_q.block_index;
          used_new = (used != '0) ? used - USED_W'(1) : '0;
        end
      end
      ACT_CHAIN: begin
        if (!valid_q) begin
          st = ST_IGNORED;
        end else if (too_long) begin
          st = ST_TOO_LONG;
        end else begin
          fin_we   = 1'b1;
          fin_addr = AW'(last);
          head_new = req_q.block_index;
          used_new = (used_ext > cnt_ext) ? USED_W'(used_ext - cnt_ext) : '0;
        end
      end
      ACT_LINK: begin
        if (!valid_q || !target_ok_q) begin
          st = ST_IGNORED;
        end else begin
          fin_we   = 1'b1;
          fin_data = req_q.link_target;
        end
      end
      ACT_READ: begin
        if (!valid_q) begin
          st = ST_IGNORED;
        end else begin
          bout = ram_rdata;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // write port: format sweep or the finishing write
  always_comb begin
    if (cmd.fmt_step) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(fmt_idx);
      ram_wdata = stat.fmt_last ? '0 : PTR_W'(fmt_idx + USED_W'(1));
    end else begin
      ram_we    = cmd.finish && fin_we;
      ram_waddr = fin_addr;
      ram_wdata = fin_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      used <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        head <= head_new;
        used <= used_new;
      end
    end
  end

  // transaction and working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q       <= req;
      valid_q     <= in_valid;
      target_ok_q <= in_target_ok;
      fmt_total   <= in_total;
      fmt_idx     <= USED_W'(1);
      last        <= req.block_index;
      count       <= CNT_W'(1);
      too_long    <= 1'b0;
    end
    if (cmd.fmt_step) begin
      fmt_idx <= fmt_idx + USED_W'(1);
    end
    if (cmd.walk_step && (ram_rdata != '0)) begin
      last     <= ram_rdata;
      count    <= count + CNT_W'(1);
      too_long <= count_full;
    end
    if (cmd.finish) begin
      rsp.block_out  <= bout;
      rsp.status     <= st;
      rsp.used_count <= used_new;
      rsp.free_head  <= head_new;
    end
  end

endmodule

@@ design/block_free_list_allocator_core.sv @@
// Free-list block allocator: allocate, free, link and read pass from acceptance
// through the finish state to the done strobe; format with a total of at least
// 2 first sweeps the table (one table write per chained block), chain release on
// a valid block first walks the chain (one read per cycle). A new command is accepted in
// the cycle the done strobe shows; the receiver cannot stall. Reset clears the free-list head, used
// count and sequencer; the next-pointer table is not cleared.
`timescale 1ns / 1ps

module block_free_list_allocator_core #(
  parameter int BLOCK_COUNT = bfla_pkg::BLOCK_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bfla_pkg::req_t req,
  output logic           done,
  output bfla_pkg::rsp_t rsp
);
  import bfla_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfla_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  bfla_datapath #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .done(done),
    .rsp (rsp)
  );

endmodule

@@ design/bfla_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
// Depends on bfla_pkg and block_free_list_allocator_core.
`timescale 1ns / 1ps

module bfla_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input bfla_pkg::rsp_t rsp
);
  import bfla_pkg::*;

  // the finish state is always followed by idle, so strobes never abut
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe in two consecutive cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after an accepted transaction");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result in the cycle after acceptance");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (rsp.block_out == '0))
    else $error("disk full result carries a block");

endmodule

bind block_free_list_allocator_core bfla_checker u_bfla_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);
